### hdl/event_stream_line_parser_macros.svh
// ----------------------------------------------------------------------------
// Event stream line parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_STREAM_LINE_PARSER_MACROS_SVH
`define EVENT_STREAM_LINE_PARSER_MACROS_SVH

// Same-cycle implication.
`define ESL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/esl_pkg.sv
// ----------------------------------------------------------------------------
// Event stream line parser package
// Types, constants and the per-byte parsing function.
// ----------------------------------------------------------------------------
package esl_pkg;

  localparam logic [7:0]  CharCr         = 8'h0D;
  localparam logic [7:0]  CharLf         = 8'h0A;
  localparam logic [7:0]  CharColon      = 8'h3A;
  localparam logic [7:0]  CharSpace      = 8'h20;
  localparam logic [7:0]  CharZero       = 8'h30;
  localparam logic [7:0]  CharNine       = 8'h39;
  localparam logic [63:0] DefaultRetryMs = 64'd3000;

  typedef enum logic [2:0] {
    PH_NAME, PH_DATA, PH_EVENT, PH_ID, PH_RETRY, PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    NM_START, NM_DATA, NM_EVENT, NM_ID, NM_RETRY, NM_NONE
  } match_e;

  typedef enum logic [2:0] {
    KIND_DATA_BYTE, KIND_EVENT_START, KIND_EVENT_BYTE, KIND_ID_START,
    KIND_ID_BYTE, KIND_BLANK, KIND_RETRY
  } kind_e;

  typedef struct packed {
    phase_e      line_phase;
    match_e      name_match;
    logic [2:0]  name_length;
    logic        after_colon;
    logic        pending_cr;
    logic        line_partial;
    logic        data_seen;
    logic [63:0] retry_accum;
    logic        retry_valid;
    logic        value_seen;
  } state_t;

  localparam state_t StateReset = '{
    line_phase:   PH_NAME,
    name_match:   NM_START,
    name_length:  3'd0,
    after_colon:  1'b0,
    pending_cr:   1'b0,
    line_partial: 1'b0,
    data_seen:    1'b0,
    retry_accum:  64'd0,
    retry_valid:  1'b1,
    value_seen:   1'b0
  };

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        dispatch;
    logic [63:0] retry_ms;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } pair_t;

  typedef struct packed {
    state_t st;
    logic   tv;
    tok_t   tok;
  } feed_t;

  function automatic tok_t esl_tok(kind_e kind, logic [7:0] b, logic disp,
                                   logic [63:0] retry);
    tok_t t;
    t.kind     = kind;
    t.out_byte = b;
    t.dispatch = disp;
    t.retry_ms = retry;
    return t;
  endfunction

  function automatic logic [2:0] esl_name_len(match_e m);
    logic [2:0] len;
    case (m)
      NM_DATA:  len = 3'd4;
      NM_EVENT: len = 3'd5;
      NM_ID:    len = 3'd2;
      NM_RETRY: len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] esl_name_char(match_e m, logic [2:0] pos);
    logic [39:0] text;
    logic [7:0]  c;
    case (m)
      NM_DATA:  text = {8'h00, "atad"};
      NM_EVENT: text = "tneve";
      NM_ID:    text = {24'h0, "di"};
      NM_RETRY: text = "yrter";
      default:  text = 40'h0;
    endcase
    case (pos)
      3'd0:    c = text[7:0];
      3'd1:    c = text[15:8];
      3'd2:    c = text[23:16];
      3'd3:    c = text[31:24];
      3'd4:    c = text[39:32];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic match_e esl_matched(state_t st);
    match_e m;
    m = NM_NONE;
    if (esl_name_len(st.name_match) != 3'd0 &&
        st.name_length == esl_name_len(st.name_match)) begin
      m = st.name_match;
    end
    return m;
  endfunction

  function automatic feed_t esl_feed(state_t st, logic [7:0] b, logic [63:0] dflt);
    feed_t       r;
    logic        absorbed;
    logic        skip;
    logic [7:0]  diff;
    logic [67:0] acc10;
    match_e      mf;
    r.st     = st;
    r.tv     = 1'b0;
    r.tok    = '0;
    absorbed = 1'b0;
    diff     = b - CharZero;
    acc10    = ({4'b0, st.retry_accum} << 3) + ({4'b0, st.retry_accum} << 1)
               + {64'b0, diff[3:0]};
    mf       = esl_matched(st);
    if (st.pending_cr) begin
      r.st.pending_cr = 1'b0;
      absorbed = (b == CharLf);
    end
    if (!absorbed) begin
      if (b == CharCr || b == CharLf) begin
        if (b == CharCr) begin
          r.st.pending_cr = 1'b1;
        end
        if (!st.line_partial) begin
          r.tv = 1'b1;
          r.tok = esl_tok(KIND_BLANK, 8'h00, st.data_seen, 64'd0);
          r.st.data_seen = 1'b0;
        end else if (st.line_phase == PH_NAME) begin
          case (mf)
            NM_DATA: begin
              r.tv = st.data_seen;
              r.tok = esl_tok(KIND_DATA_BYTE, CharLf, 1'b0, 64'd0);
              r.st.data_seen = 1'b1;
            end
            NM_EVENT: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_EVENT_START, 8'h00, 1'b0, 64'd0);
            end
            NM_ID: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_ID_START, 8'h00, 1'b0, 64'd0);
            end
            NM_RETRY: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_RETRY, 8'h00, 1'b0, dflt);
            end
            default: begin
            end
          endcase
        end else if (st.line_phase == PH_RETRY) begin
          if (!st.value_seen) begin
            r.tv = 1'b1;
            r.tok = esl_tok(KIND_RETRY, 8'h00, 1'b0, dflt);
          end else if (st.retry_valid) begin
            r.tv = 1'b1;
            r.tok = esl_tok(KIND_RETRY, 8'h00, 1'b0, st.retry_accum);
          end
        end
        r.st.line_phase   = PH_NAME;
        r.st.name_match   = NM_START;
        r.st.name_length  = 3'd0;
        r.st.after_colon  = 1'b0;
        r.st.line_partial = 1'b0;
      end else if (st.line_phase == PH_NAME) begin
        if (b == CharColon) begin
          if (!st.line_partial) begin
            r.st.line_phase = PH_SKIP;
          end else begin
            case (mf)
              NM_DATA: begin
                r.tv = st.data_seen;
                r.tok = esl_tok(KIND_DATA_BYTE, CharLf, 1'b0, 64'd0);
                r.st.data_seen = 1'b1;
                r.st.line_phase = PH_DATA;
              end
              NM_EVENT: begin
                r.tv = 1'b1;
                r.tok = esl_tok(KIND_EVENT_START, 8'h00, 1'b0, 64'd0);
                r.st.line_phase = PH_EVENT;
              end
              NM_ID: begin
                r.tv = 1'b1;
                r.tok = esl_tok(KIND_ID_START, 8'h00, 1'b0, 64'd0);
                r.st.line_phase = PH_ID;
              end
              NM_RETRY: begin
                r.st.line_phase  = PH_RETRY;
                r.st.retry_accum = 64'd0;
                r.st.retry_valid = 1'b1;
                r.st.value_seen  = 1'b0;
              end
              default: r.st.line_phase = PH_SKIP;
            endcase
          end
          r.st.after_colon = 1'b1;
        end else if (st.name_match == NM_START) begin
          case (b)
            "d":     r.st.name_match = NM_DATA;
            "e":     r.st.name_match = NM_EVENT;
            "i":     r.st.name_match = NM_ID;
            "r":     r.st.name_match = NM_RETRY;
            default: r.st.name_match = NM_NONE;
          endcase
          r.st.name_length = 3'd1;
        end else if (st.name_match != NM_NONE) begin
          if (st.name_length < esl_name_len(st.name_match) &&
              esl_name_char(st.name_match, st.name_length) == b) begin
            r.st.name_length = st.name_length + 3'd1;
          end else begin
            r.st.name_match = NM_NONE;
          end
        end
        r.st.line_partial = 1'b1;
      end else begin
        skip = st.after_colon && (b == CharSpace);
        r.st.after_colon = 1'b0;
        if (!skip) begin
          case (st.line_phase)
            PH_DATA: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_DATA_BYTE, b, 1'b0, 64'd0);
            end
            PH_EVENT: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_EVENT_BYTE, b, 1'b0, 64'd0);
            end
            PH_ID: begin
              r.tv = 1'b1;
              r.tok = esl_tok(KIND_ID_BYTE, b, 1'b0, 64'd0);
            end
            PH_RETRY: begin
              r.st.value_seen = 1'b1;
              if (b >= CharZero && b <= CharNine && st.retry_valid &&
                  acc10[67:64] == 4'd0) begin
                r.st.retry_accum = acc10[63:0];
              end else begin
                r.st.retry_valid = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    return r;
  endfunction

endpackage

### hdl/event_stream_line_parser.sv
// ----------------------------------------------------------------------------
// Event stream line parser
// Parses an event stream byte by byte into data, event, id, retry and
// blank line tokens.
// ----------------------------------------------------------------------------
// The parser takes two kinds of request: a stream byte, or an end-of-stream
// flush selected by tuser. A request passes through an input register, is
// parsed against the line state, and its tokens land in an output register,
// from which they are presented. A byte gives at most one token and sustains
// one request per cycle while the output takes each token; a flush may give
// two tokens, and the next request is held until the last of them is taken.
// The retry default register takes a write in any cycle and should only be
// written while no request is in flight.
module event_stream_line_parser import esl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] out_byte, [8] dispatch, [72:9] retry_ms
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

`include "event_stream_line_parser_macros.svh"

  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       buf_free;
  pair_t      pair;
  tok_t       tok;

  assign fire          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
  end

  esl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .fire_i      (fire),
    .op_i        (in_op_q),
    .byte_i      (in_byte_q),
    .pair_o      (pair)
  );

  esl_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .pair_i  (pair),
    .free_o  (buf_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, tok.retry_ms, tok.dispatch, tok.out_byte};
  assign m_axis_tuser = tok.kind;

  `ESL_ASSERT_NEXT(a_held_request_kept, in_valid_q && !fire, in_valid_q,
                   "held request was dropped")
  `ESL_ASSERT_NEXT(a_last_drains, m_axis_tvalid && m_axis_tready && m_axis_tlast && !fire,
                   !m_axis_tvalid, "output still valid after last token")
  `ESL_ASSERT_IMPL(a_dispatch_blank_only, m_axis_tvalid && tok.kind != KIND_BLANK,
                   !tok.dispatch, "dispatch set on a non-blank token")
  `ESL_ASSERT_IMPL(a_retry_field_only, m_axis_tvalid && tok.kind != KIND_RETRY,
                   tok.retry_ms == 64'd0, "retry value set on a non-retry token")

endmodule

### hdl/esl_core.sv
// ----------------------------------------------------------------------------
// Event stream line parser core
// Parser state, the retry default register and token generation per request.
// ----------------------------------------------------------------------------
module esl_core import esl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [63:0] cfg_data_i,
  output logic        cfg_ready_o,
  input  logic        fire_i,
  input  logic        op_i,
  input  logic [7:0]  byte_i,
  output pair_t       pair_o
);

  state_t      st_q, st_d;
  logic [63:0] dflt_q;
  feed_t       f_byte, f_lf1, f_lf2;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    f_byte = esl_feed(st_q, byte_i, dflt_q);
    f_lf1  = esl_feed(st_q, CharLf, dflt_q);
    f_lf2  = esl_feed(f_lf1.st, CharLf, dflt_q);
    pair_o = '0;
    st_d   = st_q;
    if (!op_i) begin
      st_d        = f_byte.st;
      pair_o.cnt  = {1'b0, f_byte.tv};
      pair_o.tok0 = f_byte.tok;
    end else if (st_q.line_partial || st_q.data_seen) begin
      st_d            = f_lf2.st;
      st_d.pending_cr = 1'b0;
      pair_o.cnt      = {1'b0, f_lf1.tv} + {1'b0, f_lf2.tv};
      pair_o.tok0     = f_lf1.tv ? f_lf1.tok : f_lf2.tok;
      pair_o.tok1     = f_lf2.tok;
    end else begin
      st_d.pending_cr = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StateReset;
      dflt_q <= DefaultRetryMs;
    end else begin
      if (fire_i) begin
        st_q <= st_d;
      end
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

endmodule

### hdl/esl_out_buf.sv
// ----------------------------------------------------------------------------
// Event stream line parser output buffer
// Holds the tokens of one request and presents them one per transfer.
// ----------------------------------------------------------------------------
module esl_out_buf import esl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  pair_t pair_i,
  output logic  free_o,
  output logic  valid_o,
  input  logic  ready_i,
  output tok_t  tok_o,
  output logic  last_o
);

  logic [1:0] cnt_q;
  logic       idx_q;
  tok_t       tok0_q, tok1_q;
  logic       take;

  assign valid_o = (cnt_q != 2'd0);
  assign tok_o   = idx_q ? tok1_q : tok0_q;
  assign last_o  = ({1'b0, idx_q} == cnt_q - 2'd1);
  assign take    = valid_o && ready_i;
  assign free_o  = !valid_o || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 1'b0;
    end else begin
      if (take) begin
        if (last_o) begin
          cnt_q <= 2'd0;
        end else begin
          idx_q <= 1'b1;
        end
      end
      if (load_i && pair_i.cnt != 2'd0) begin
        cnt_q <= pair_i.cnt;
        idx_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok0_q <= pair_i.tok0;
      tok1_q <= pair_i.tok1;
    end
  end

endmodule
